### sv/ord_pkg.sv
// Package for the output-restricted deque: request and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package ord_pkg;

  localparam int unsigned DEPTH_DEFAULT = 8;
  localparam int unsigned DATA_W        = 32;

  typedef enum logic [1:0] {
    REQ_INS_REAR  = 2'd0,
    REQ_INS_FRONT = 2'd1,
    REQ_DEL_FRONT = 2'd2,
    REQ_READ_OUT  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOFRONT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture the accepted request
    logic exec;      // finish a request that needs no slot read
    logic rd_start;  // read slot at front, start walk
    logic rd_next;   // read next slot of the walk
    logic take_rd;   // load read word into the result register
  } ord_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_read;  // delete or read out on a non-empty deque
    logic walk_more;   // read out has words left after the current beat
  } ord_sts_t;

endpackage

### sv/ord_if.sv
// Channel interfaces of the output-restricted deque: request and result.
// Depends on ord_pkg.
interface ord_req_if import ord_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output req_type, output data_in, input ready);
  modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

interface ord_rsp_if import ord_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data_out;
  logic                     last;

  modport source (output valid, output status, output data_out, output last, input ready);
  modport sink   (input valid, input status, input data_out, input last, output ready);
endinterface

### sv/ord_ctrl.sv
// Controller of the output-restricted deque: sequences accept, decide, slot read
// and result beats. Depends on ord_pkg.
module ord_ctrl import ord_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  ord_sts_t sts_i,
  output ord_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = sts_i.needs_read ? S_READ : S_OUT;
      end
      S_READ: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = sts_i.walk_more ? S_READ : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == S_IDLE);
    out_valid_o      = (state_q == S_OUT);
    cmd_o.latch      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec       = (state_q == S_DECIDE) && !sts_i.needs_read;
    cmd_o.rd_start   = (state_q == S_DECIDE) && sts_i.needs_read;
    cmd_o.take_rd    = (state_q == S_READ);
    cmd_o.rd_next    = (state_q == S_OUT) && out_ready_i && sts_i.walk_more;
  end

endmodule

### sv/ord_dp.sv
// Datapath of the output-restricted deque: slot memory, front/rear indices,
// walk pointer and result register. Depends on ord_pkg.
module ord_dp import ord_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [1:0]               req_type_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  input  ord_cmd_t                 cmd_i,
  output ord_sts_t                 sts_o,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic                     last_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];

  req_e              req_q;
  logic [DATA_W-1:0] din_q;
  logic [IdxW-1:0]   front_q, front_d;
  logic [CntW-1:0]   rear_q, rear_d;
  logic [IdxW-1:0]   ptr_q;
  logic [DATA_W-1:0] rd_data_q;
  status_e           status_q;
  logic [DATA_W-1:0] dout_q;
  logic              last_q;

  logic              empty;
  logic [CntW-1:0]   front_inc, ptr_inc;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  status_e           exec_status;

  assign empty     = ({1'b0, front_q} >= rear_q);
  assign front_inc = {1'b0, front_q} + CntW'(1);
  assign ptr_inc   = {1'b0, ptr_q} + CntW'(1);
  assign rd_addr   = cmd_i.rd_next ? ptr_inc[IdxW-1:0] : front_q;

  assign sts_o.needs_read = ((req_q == REQ_DEL_FRONT) || (req_q == REQ_READ_OUT)) && !empty;
  assign sts_o.walk_more  = (req_q == REQ_READ_OUT) && !last_q;

  // index update and write for requests that finish without a slot read, and the front advance of a delete
  always_comb begin
    front_d     = front_q;
    rear_d      = rear_q;
    wr_en       = 1'b0;
    wr_addr     = rear_q[IdxW-1:0];
    exec_status = ST_EMPTY;
    if (cmd_i.exec) begin
      unique case (req_q)
        REQ_INS_REAR: begin
          if (rear_q >= DepthC) begin
            exec_status = ST_OVERFLOW;
          end else begin
            exec_status = ST_OK;
            wr_en       = 1'b1;
            wr_addr     = rear_q[IdxW-1:0];
            rear_d      = rear_q + CntW'(1);
          end
        end
        REQ_INS_FRONT: begin
          if (front_q != '0) begin
            exec_status = ST_OK;
            wr_en       = 1'b1;
            wr_addr     = front_q - IdxW'(1);
            front_d     = front_q - IdxW'(1);
          end else if (rear_q == '0) begin
            exec_status = ST_OK;
            wr_en       = 1'b1;
            wr_addr     = '0;
            rear_d      = CntW'(1);
          end else begin
            exec_status = ST_NOFRONT;
          end
        end
        default: exec_status = ST_EMPTY;  // delete / read out on empty deque
      endcase
    end else if (cmd_i.take_rd && (req_q == REQ_DEL_FRONT)) begin
      if (front_inc >= rear_q) begin
        front_d = '0;
        rear_d  = '0;
      end else begin
        front_d = front_inc[IdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q   <= REQ_INS_REAR;
      front_q <= '0;
      rear_q  <= '0;
      ptr_q   <= '0;
    end else begin
      if (cmd_i.latch) req_q <= req_e'(req_type_i);
      front_q <= front_d;
      rear_q  <= rear_d;
      if (cmd_i.rd_start || cmd_i.rd_next) ptr_q <= rd_addr;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= din_q;
    if (cmd_i.rd_start || cmd_i.rd_next) rd_data_q <= mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) din_q <= data_in_i;
    if (cmd_i.exec) begin
      status_q <= exec_status;
      dout_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.take_rd) begin
      status_q <= ST_OK;
      dout_q   <= rd_data_q;
      last_q   <= (req_q == REQ_DEL_FRONT) ? 1'b1 : (ptr_inc >= rear_q);
    end
  end

  assign status_o   = status_q;
  assign data_out_o = dout_q;
  assign last_o     = last_q;

  a_rear_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rear_q <= DepthC) else $error("rear index beyond depth");

  a_empty_front_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rear_q == '0) |-> (front_q == '0)) else $error("front index set on empty deque");

  a_front_below_rear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rear_q != '0) |-> ({1'b0, front_q} < rear_q)) else $error("front not below rear");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_start || cmd_i.rd_next) |=> ({1'b0, ptr_q} < rear_q))
    else $error("slot read outside held words");

endmodule

### sv/output_restricted_deque_top.sv
// Top level of the output-restricted deque (linear array, no wrap).
// Depends on ord_pkg, ord_if, ord_ctrl, ord_dp.
//
// Usage:
//   req_i  (sink):   one beat per request; req_type selects insert rear,
//                    insert front, delete front or read out; data_in is
//                    the word to insert.
//   rsp_o  (source): result beats with status, data_out and last. Insert
//                    and delete give one beat; read out gives one beat per
//                    held word, front to rear, last set on the final one
//                    (a single empty-status beat if nothing is held).
// Sequence:
//   A request is taken only when the block is idle, so the next request is
//   taken only after the last result beat of the one before. Inserts and
//   requests that find the deque empty go from accept through the decide
//   state to their result beat; delete adds the registered slot read. Read
//   out gives one slot-memory read followed by its result beat per word.
// Reset:
//   Indices clear to empty; slot contents are not cleared and no sweep runs.
//   The block takes a request as soon as reset is released.
// Stall:
//   A result waits in its register while rsp_o.ready is low; the walk of a
//   read out pauses with it and no request is taken meanwhile.
module output_restricted_deque_top import ord_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ord_req_if.sink   req_i,
  ord_rsp_if.source rsp_o
);

  ord_cmd_t cmd;
  ord_sts_t sts;

  ord_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ord_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_type_i (req_i.req_type),
    .data_in_i  (req_i.data_in),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .status_o   (rsp_o.status),
    .data_out_o (rsp_o.data_out),
    .last_o     (rsp_o.last)
  );

endmodule

### bench/output_restricted_deque_top_test.sv
// Self-checking bench for output_restricted_deque_top: directed corner cases, then random
// request traffic under several idle/stall mixes, each result beat checked against a predictor.
// Depends on ord_pkg, ord_if and the RTL of output_restricted_deque_top.
`timescale 1ns / 100ps

module output_restricted_deque_top_test;
  import ord_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEFAULT;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 8;  // longest read out, plus margin

  typedef struct {
    status_e           status;
    logic [DATA_W-1:0] data;
    logic              last;
  } deque_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ord_req_if req_if ();
  ord_rsp_if rsp_if ();

  output_restricted_deque_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the deque, updated as each request beat is accepted.
  logic [DATA_W-1:0] dq_slots [DEPTH];
  logic [IDX_W-1:0]  dq_front;
  logic [IDX_W:0]    dq_rear;   // one past the rear word; equal to front means empty

  deque_beat_t results_due[$];

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned cycle_count   = 0;
  int unsigned fault_count   = 0;
  int unsigned req_count     = 0;
  int unsigned beat_count    = 0;

  function automatic void push_due(status_e st, logic [DATA_W-1:0] word, logic fin);
    deque_beat_t b;
    b.status = st;
    b.data   = word;
    b.last   = fin;
    results_due.push_back(b);
  endfunction

  function automatic bit deque_is_empty();
    return dq_front >= dq_rear;
  endfunction

  // Works out the beats one request causes and moves the shadow state on.
  function automatic void apply_deque_request(req_e op, logic [DATA_W-1:0] word);
    logic [IDX_W:0] nxt;
    case (op)
      REQ_INS_REAR: begin
        if (dq_rear >= DEPTH) begin
          push_due(ST_OVERFLOW, '0, 1'b1);
        end else begin
          dq_slots[dq_rear[IDX_W-1:0]] = word;
          dq_rear = dq_rear + 1'b1;
          push_due(ST_OK, '0, 1'b1);
        end
      end
      REQ_INS_FRONT: begin
        if (dq_front != 0) begin
          dq_front = dq_front - 1'b1;
          dq_slots[dq_front] = word;
          push_due(ST_OK, '0, 1'b1);
        end else if (dq_rear == 0) begin
          // empty deque: word lands in slot 0
          dq_slots[0] = word;
          dq_rear = (IDX_W+1)'(1);
          push_due(ST_OK, '0, 1'b1);
        end else begin
          push_due(ST_NOFRONT, '0, 1'b1);
        end
      end
      REQ_DEL_FRONT: begin
        if (deque_is_empty()) begin
          push_due(ST_EMPTY, '0, 1'b1);
        end else begin
          push_due(ST_OK, dq_slots[dq_front], 1'b1);
          nxt = dq_front + 1'b1;
          if (nxt >= dq_rear) begin
            // last word gone: both indices back to zero
            dq_front = '0;
            dq_rear  = '0;
          end else begin
            dq_front = nxt[IDX_W-1:0];
          end
        end
      end
      default: begin
        if (deque_is_empty()) begin
          push_due(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = dq_front; i < dq_rear; i++) begin
            push_due(ST_OK, dq_slots[i], (i + 1 >= dq_rear));
          end
        end
      end
    endcase
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  // Response side: check each accepted beat, then pick ready for the next cycle.
  always @(posedge clk_i) begin
    deque_beat_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      beat_count++;
      if (results_due.size() == 0) begin
        note_fault($sformatf("unexpected beat status=%0d data=%h last=%b",
                             rsp_if.status, rsp_if.data_out, rsp_if.last));
      end else begin
        want = results_due.pop_front();
        if (rsp_if.status !== want.status || rsp_if.data_out !== want.data ||
            rsp_if.last !== want.last) begin
          note_fault($sformatf("beat %0d: status %0d/%0d data %h/%h last %b/%b (exp/got)",
                               beat_count, want.status, rsp_if.status, want.data,
                               rsp_if.data_out, want.last, rsp_if.last));
        end
      end
    end
    rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d beats still due", $realtime, results_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sends one request beat; valid is left high so back-to-back beats need no toggle.
  task automatic send_request(req_e op, logic [DATA_W-1:0] word);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.data_in  <= word;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    req_count++;
    apply_deque_request(op, word);
  endtask

  // Sender holds off until every due beat has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_requests();
    send_request(REQ_READ_OUT, 32'h1234_5678);   // read out of empty deque
    send_request(REQ_DEL_FRONT, 32'hFFFF_FFFF);  // delete from empty deque
    send_request(REQ_INS_FRONT, 32'h8000_0000);  // front insert into empty: slot 0
    send_request(REQ_INS_FRONT, 32'h0000_0001);  // front at slot 0, not empty: refused
  endtask

  task automatic test_fill_and_overflow();
    send_request(REQ_INS_REAR, 32'h7FFF_FFFF);
    send_request(REQ_INS_REAR, 32'hFFFF_FFFF);
    send_request(REQ_INS_REAR, 32'h0000_0000);
    for (int i = 3; i < DEPTH; i++) send_request(REQ_INS_REAR, $urandom);
    send_request(REQ_INS_REAR, 32'hA5A5_A5A5);  // rear at last slot: overflow
    send_request(REQ_READ_OUT, '0);             // full read out
  endtask

  task automatic test_front_refill_and_drain();
    send_request(REQ_DEL_FRONT, '0);
    send_request(REQ_DEL_FRONT, '0);
    send_request(REQ_INS_FRONT, 32'h5555_5555);
    send_request(REQ_INS_FRONT, 32'hAAAA_AAAA);
    send_request(REQ_READ_OUT, '0);
    while (!deque_is_empty()) send_request(REQ_DEL_FRONT, $urandom);
    // indices reset on the final delete, so a front insert goes in again
    send_request(REQ_INS_FRONT, 32'h0F0F_0F0F);
    send_request(REQ_DEL_FRONT, '0);
    wait_drained();
  endtask

  // Random traffic: fill runs up to overflow, then drain runs down to empty, with front
  // inserts landing in the slots freed by deletes.
  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                     int unsigned n_items);
    bit          filling;
    int unsigned r;
    req_e        op;
    filling       = 1'b1;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k == n_items / 2) wait_drained();
      if (dq_rear == DEPTH && $urandom_range(2) == 0) filling = 1'b0;
      if (deque_is_empty()) filling = 1'b1;
      r = $urandom_range(99);
      if (filling) begin
        op = (r < 50) ? REQ_INS_REAR : (r < 70) ? REQ_INS_FRONT :
             (r < 88) ? REQ_DEL_FRONT : REQ_READ_OUT;
      end else begin
        op = (r < 12) ? REQ_INS_REAR : (r < 30) ? REQ_INS_FRONT :
             (r < 85) ? REQ_DEL_FRONT : REQ_READ_OUT;
      end
      send_request(op, pick_word());
    end
    wait_drained();
  endtask

  initial begin
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_INS_REAR;
    req_if.data_in  <= '0;
    dq_front = '0;
    dq_rear  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_requests();
    test_fill_and_overflow();
    test_front_refill_and_drain();
    test_random_traffic(0, 0, 100);
    test_random_traffic(85, 0, 100);
    test_random_traffic(0, 85, 100);
    test_random_traffic(21, 21, 100);

    // beats may still be in flight after the last due one; give the block time
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (results_due.size() != 0) note_fault($sformatf("%0d beats never arrived",
                                                      results_due.size()));

    $display("Sent %0d requests (empty, overflow, refused front insert, read out corners",
             req_count);
    $display("plus random traffic under four idle/stall mixes); %0d result beats, %0d faults",
             beat_count, fault_count);
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
